// ===== hw/rtl/rsf_pkg.sv =====
package rsf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 16;
    localparam int INROW_W    = HREG_W + 1;
    localparam int PIX_W      = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 16'd480;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Line store read request issued in the accept cycle.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic              valid;
        logic              take;
        logic [PIX_W-1:0]  pix;
        logic [ADDR_W-1:0] x;
        logic              emit;
        logic              up;
        logic              dn;
        logic              lf;
        logic              rt;
        logic              last;
    } cmd_t;

    // One channel of the sharpen kernel: 5*center minus present neighbors,
    // magnitude, halved on a border, low 8 bits.
    function automatic logic [7:0] filter_chan(
        input logic [7:0] c,
        input logic [7:0] u,
        input logic [7:0] d,
        input logic [7:0] l,
        input logic [7:0] r,
        input logic       up,
        input logic       dn,
        input logic       lf,
        input logic       rt
    );
        logic [12:0] s;
        logic [12:0] mag;
        s = {3'b0, c, 2'b0} + {5'b0, c};
        if (up) s = s - {5'b0, u};
        if (dn) s = s - {5'b0, d};
        if (lf) s = s - {5'b0, l};
        if (rt) s = s - {5'b0, r};
        mag = s[12] ? (13'd0 - s) : s;
        if (!(up && dn && lf && rt)) mag = mag >> 1;
        return mag[7:0];
    endfunction

endpackage

// ===== hw/rtl/rsf_front.sv =====
module rsf_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [0:0]               cfg_addr,
    input  logic [15:0]              cfg_wr_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [rsf_pkg::PIX_W-1:0] s_tdata,
    input  logic                     s_tuser,
    input  logic                     credit_ok,
    output rsf_pkg::rd_req_t         rd_req,
    output rsf_pkg::cmd_t            cmd
);
    import rsf_pkg::*;

    logic [WREG_W-1:0]  width_reg, width_next;
    logic [HREG_W-1:0]  height_reg, height_next;
    logic [ADDR_W-1:0]  in_col_reg, in_col_next;
    logic [INROW_W-1:0] in_row_reg, in_row_next;
    logic [ADDR_W-1:0]  out_col_reg, out_col_next;
    logic [HREG_W-1:0]  out_row_reg, out_row_next;
    cmd_t               cmd_reg, cmd_next;

    logic [WREG_W-1:0] eff_w;
    logic [HREG_W-1:0] eff_h;
    logic [ADDR_W-1:0] wm1;
    logic [HREG_W-1:0] hm1;
    logic accept, complete, take, emit, last;

    // Effective frame size after clamping.
    always_comb begin
        if (width_reg == '0) begin
            eff_w = WREG_W'(1);
        end else if (width_reg > WREG_W'(MAX_WIDTH)) begin
            eff_w = WREG_W'(MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? HREG_W'(1) : height_reg;
    end

    assign wm1 = ADDR_W'(eff_w - WREG_W'(1));
    assign hm1 = eff_h - HREG_W'(1);

    // Classification of the request at the input.
    assign s_tready = credit_ok;
    assign accept   = s_tvalid && s_tready;
    assign complete = in_row_reg >= {1'b0, eff_h};
    assign take     = accept && (s_tuser == complete);
    assign emit     = take
                      && ((in_row_reg >= INROW_W'(2))
                          || ((in_row_reg == INROW_W'(1)) && (in_col_reg != '0)))
                      && (out_row_reg < eff_h);
    assign last     = (out_col_reg == wm1) && (out_row_reg == hm1);

    assign rd_req.en   = take;
    assign rd_req.addr = in_col_reg;

    // Command for the back end.
    always_comb begin
        cmd_next.valid = accept;
        cmd_next.take  = take;
        cmd_next.pix   = s_tuser ? '0 : s_tdata;
        cmd_next.x     = in_col_reg;
        cmd_next.emit  = emit;
        cmd_next.up    = out_row_reg != '0;
        cmd_next.dn    = out_row_reg < hm1;
        cmd_next.lf    = out_col_reg != '0;
        cmd_next.rt    = out_col_reg < wm1;
        cmd_next.last  = last;
    end

    // Frame position and configuration.
    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_next  = cfg_wr_data[WREG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_wr_data[HREG_W-1:0];
                default:          width_next  = width_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (take) begin
            if (emit && last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (in_col_reg == wm1) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + INROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + ADDR_W'(1);
                end
                if (emit) begin
                    if (out_col_reg == wm1) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + HREG_W'(1);
                    end else begin
                        out_col_next = out_col_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            cmd_reg     <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            cmd_reg     <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

endmodule

// ===== hw/rtl/rsf_back.sv =====
module rsf_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rsf_pkg::rd_req_t          rd_req,
    input  rsf_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      push,
    output logic [rsf_pkg::PIX_W:0]   push_data
);
    import rsf_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_W-1:0] rd_up_reg, rd_mid_reg;
    logic             byp_reg;
    logic [PIX_W-1:0] byp_up_reg, byp_mid_reg;
    logic [PIX_W-1:0] up_old, mid_old;
    logic [PIX_W-1:0] win_reg [3][3];
    cmd_t             c_reg;
    logic             shift;

    assign shift = cmd.valid && cmd.take;

    // A write from the previous request to the same column is forwarded.
    assign up_old  = byp_reg ? byp_up_reg  : rd_up_reg;
    assign mid_old = byp_reg ? byp_mid_reg : rd_mid_reg;

    // Line stores: read in the accept cycle, written in the following cycle.
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_up_reg  <= upper_mem[rd_req.addr];
            rd_mid_reg <= middle_mem[rd_req.addr];
        end
        if (shift) begin
            upper_mem[cmd.x]  <= mid_old;
            middle_mem[cmd.x] <= cmd.pix;
        end
        byp_up_reg  <= mid_old;
        byp_mid_reg <= cmd.pix;
    end

    // Window shift and result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
            c_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else begin
            byp_reg <= rd_req.en && shift && (rd_req.addr == cmd.x);
            c_reg   <= cmd;
            if (shift) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up_old;
                win_reg[1][2] <= mid_old;
                win_reg[2][2] <= cmd.pix;
            end
        end
    end

    // Kernel on each byte lane of the window.
    always_comb begin
        push_data[PIX_W] = c_reg.last;
        for (int b = 0; b < 3; b++) begin
            push_data[b*8 +: 8] = filter_chan(
                win_reg[1][1][b*8 +: 8], win_reg[0][1][b*8 +: 8],
                win_reg[2][1][b*8 +: 8], win_reg[1][0][b*8 +: 8],
                win_reg[1][2][b*8 +: 8], c_reg.up, c_reg.dn, c_reg.lf, c_reg.rt);
        end
    end

    assign push = c_reg.valid && c_reg.emit;
    assign busy = c_reg.valid;

endmodule

// ===== hw/rtl/rsf_fifo.sv =====
module rsf_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  logic [rsf_pkg::PIX_W:0]         push_data,
    input  logic                            pop,
    output logic                            not_empty,
    output logic [rsf_pkg::PIX_W:0]         head,
    output logic [rsf_pkg::FIFO_CNT_W-1:0]  count
);
    import rsf_pkg::*;

    logic [PIX_W:0]          mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("result queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + FIFO_CNT_W'(1)))
        else $error("result queue count mismatch");
`endif

endmodule

// ===== hw/rtl/rgb_sharpen_3x3_filter.sv =====
// RGB 3x3 sharpen filter.
// Input channel s_*: one request per pixel in raster order (s_tuser = 0), or a
// drain request (s_tuser = 1) that flushes one pending result after the frame.
// Output channel m_*: filtered pixels; m_tlast marks the last pixel of a frame.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr
// (0 = image width, 1 = image height); any write restarts the frame.
// Each result belongs to the pixel one line plus one pixel before the request
// that produces it; it passes the command register, the line store read and
// window registers, and the kernel into the queue before it reaches m_tvalid.
// Throughput is one request per cycle while s_tready is high; the line stores take one
// read and one write per cycle and the window advances once per request.
// A four-entry result queue separates the output from the pipeline. When the
// receiver stalls, the queue fills and s_tready drops as soon as queued plus
// in-flight results could reach its depth.
// Reset returns the width to 640, the height to 480, clears the frame position
// and empties the queue; line store contents are left as they are.
module rgb_sharpen_3x3_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast    // frame_last
);
    import rsf_pkg::*;

    rd_req_t               rd_req;
    cmd_t                  cmd;
    logic                  back_busy;
    logic                  push;
    logic [PIX_W:0]        push_data;
    logic [PIX_W:0]        head;
    logic [FIFO_CNT_W-1:0] count;
    logic                  credit_ok;
    logic                  pop;

    // Room for every request that may still produce a result.
    assign credit_ok = (count + FIFO_CNT_W'(cmd.valid) + FIFO_CNT_W'(back_busy))
                       < FIFO_CNT_W'(FIFO_DEPTH);
    assign pop = m_tvalid && m_tready;

    rsf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .credit_ok   (credit_ok),
        .rd_req      (rd_req),
        .cmd         (cmd)
    );

    rsf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_req    (rd_req),
        .cmd       (cmd),
        .busy      (back_busy),
        .push      (push),
        .push_data (push_data)
    );

    rsf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (count)
    );

    assign m_tdata = head[PIX_W-1:0];
    assign m_tlast = head[PIX_W];

endmodule

// ===== bench/tb.sv =====
module tb;
    import rsf_pkg::*;

    localparam int PERIOD    = 20;
    localparam int CYC_LIMIT = 1000000;

    // One request on the input channel and one filtered pixel on the output.
    typedef struct packed {
        logic        drain;
        logic [23:0] rgb;   // red in bits 7..0, blue in 23..16
    } pix_req_t;

    typedef struct packed {
        logic [23:0] rgb;
        logic        last;
    } sharp_px_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    rgb_sharpen_3x3_filter DUT (.*);

    always #(PERIOD / 2) aclk = ~aclk;

    pix_req_t  pixel_q[$];
    sharp_px_t sharp_q[$];
    int        n_issued = 0;
    int        n_taken = 0;
    int        n_queued = 0;
    int        errors = 0;
    int        checked = 0;
    int        frames_done = 0;
    int        cycles = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    bit        calm = 0;

    // Shadow copy of the filter state.
    logic [10:0] width_reg = WIDTH_RESET;
    logic [15:0] height_reg = HEIGHT_RESET;
    logic [23:0] row_above[MAX_WIDTH];
    logic [23:0] row_mid[MAX_WIDTH];
    logic [23:0] win[3][3];
    int          col_pos = 0;
    int          row_pos = 0;
    int          done_cnt = 0;

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i] = '0;
            row_mid[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
    end

    function automatic int width_eff();
        return (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    endfunction

    function automatic int height_eff();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Sharpen one byte lane of the center pixel using the taps that exist.
    function automatic logic [7:0] sharpen_lane(int lane, bit up, bit dn, bit lf, bit rt);
        int s;
        int mag;
        s = 5 * int'(win[1][1][8*lane +: 8]);
        if (up) s -= int'(win[0][1][8*lane +: 8]);
        if (dn) s -= int'(win[2][1][8*lane +: 8]);
        if (lf) s -= int'(win[1][0][8*lane +: 8]);
        if (rt) s -= int'(win[1][2][8*lane +: 8]);
        mag = (s < 0) ? -s : s;
        if (!(up && dn && lf && rt)) mag = mag >>> 1;
        return mag[7:0];
    endfunction

    // Advance the shadow pipeline by one request and queue any pixel it completes.
    task automatic sharpen_step(pix_req_t rq);
        int w;
        int h;
        int x;
        int k;
        int r;
        int c;
        bit up;
        bit dn;
        bit lf;
        bit rt;
        logic [23:0] v;
        sharp_px_t px;
        w = width_eff();
        h = height_eff();
        if (rq.drain != (row_pos >= h)) return;
        v = rq.drain ? 24'd0 : rq.rgb;
        x = (col_pos >= w) ? 0 : col_pos;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_above[x];
        win[1][2] = row_mid[x];
        win[2][2] = v;
        row_above[x] = row_mid[x];
        row_mid[x] = v;
        k = row_pos * w + x;
        x++;
        if (x >= w) begin
            x = 0;
            row_pos++;
        end
        col_pos = x;
        if (k < w + 1 || done_cnt >= w * h) return;
        r = done_cnt / w;
        c = done_cnt % w;
        up = r > 0;
        dn = r + 1 < h;
        lf = c > 0;
        rt = c + 1 < w;
        for (int lane = 0; lane < 3; lane++)
            px.rgb[8*lane +: 8] = sharpen_lane(lane, up, dn, lf, rt);
        done_cnt++;
        px.last = (done_cnt >= w * h);
        if (px.last) begin
            col_pos = 0;
            row_pos = 0;
            done_cnt = 0;
        end
        sharp_q.push_back(px);
    endtask

    // Prediction, register shadowing and result checking at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_IMAGE_WIDTH) width_reg = cfg_wr_data[10:0];
                else height_reg = cfg_wr_data;
                col_pos = 0;
                row_pos = 0;
                done_cnt = 0;
            end
            if (s_tvalid && s_tready) begin
                sharpen_step('{drain: s_tuser, rgb: s_tdata});
                n_taken <= n_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                if (sharp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    sharp_px_t want;
                    want = sharp_q.pop_front();
                    checked++;
                    if (want.last) frames_done++;
                    if (m_tdata[7:0] != want.rgb[7:0]) begin
                        errors++;
                        $display("%0t: red expected %h actual %h", $time,
                                 want.rgb[7:0], m_tdata[7:0]);
                    end
                    if (m_tdata[15:8] != want.rgb[15:8]) begin
                        errors++;
                        $display("%0t: green expected %h actual %h", $time,
                                 want.rgb[15:8], m_tdata[15:8]);
                    end
                    if (m_tdata[23:16] != want.rgb[23:16]) begin
                        errors++;
                        $display("%0t: blue expected %h actual %h", $time,
                                 want.rgb[23:16], m_tdata[23:16]);
                    end
                    if (m_tlast != want.last) begin
                        errors++;
                        $display("%0t: frame_last expected %b actual %b", $time,
                                 want.last, m_tlast);
                    end
                end
            end
        end
    end

    // Request driver: takes the next pending request once the current one is gone.
    always @(negedge aclk) begin
        if (aresetn && n_taken == n_issued) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                in_gap <= $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                pix_req_t rq;
                rq = pixel_q.pop_front();
                s_tdata <= rq.rgb;
                s_tuser <= rq.drain;
                s_tvalid <= 1'b1;
                n_issued <= n_issued + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver backpressure.
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYC_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic settle();
        wait (pixel_q.size() == 0 && n_taken == n_issued);
        wait (sharp_q.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(logic [15:0] w, logic [15:0] h);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [23:0] rand_rgb();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hffffff;
            2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'h00, 8'hff};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_pixel(logic [23:0] rgb);
        pixel_q.push_back('{drain: 1'b0, rgb: rgb});
        n_queued++;
    endtask

    task automatic add_drain();
        pixel_q.push_back('{drain: 1'b1, rgb: 24'($urandom)});
        n_queued++;
    endtask

    // Random frame: pixels with occasional stray drains, an occasional stray pixel at the end,
    // then the drains that flush the last line plus one pixel.
    task automatic add_frame(int w, int h);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 24) == 0) add_drain();
            add_pixel(rand_rgb());
        end
        if ($urandom_range(0, 9) == 0) add_pixel(rand_rgb());
        for (int i = 0; i <= w; i++) begin
            add_drain();
        end
    endtask

    initial begin
        int w;
        int h;
        int wr;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: 3x3 frame of extreme values with a stray drain and a stray pixel.
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        add_drain();
        add_pixel(24'hffffff); add_pixel(24'h000000); add_pixel(24'hffffff);
        add_pixel(24'h000000); add_pixel(24'hffffff); add_pixel(24'h000000);
        add_pixel(24'h00ff00); add_pixel(24'hff00ff); add_pixel(24'h0000ff);
        add_pixel(24'h123456);
        repeat (4) add_drain();
        add_drain();
        // Width zero acts as one, height zero acts as one.
        set_size(16'd0, 16'd0);
        add_pixel(24'hffffff);
        repeat (2) add_drain();

        // Widest line: partial frame, cut short by a register write.
        set_size(16'd2047, 16'd2);
        for (int i = 0; i < 30; i++) add_pixel(24'($urandom));
        // Tallest frame, partial.
        set_size(16'd1, 16'd65535);
        for (int i = 0; i < 40; i++) add_pixel(rand_rgb());
        set_size(16'd1024, 16'd1);
        for (int i = 0; i < 10; i++) add_pixel(rand_rgb());

        // Random frames of small size.
        w = 4;
        h = 3;
        set_size(16'(w), 16'(h));
        while (n_queued < 850) begin
            if (n_queued > 650) calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    wr = $urandom_range(0, 12);
                    w = (wr == 0) ? 1 : wr;
                    h = $urandom_range(0, 6);
                    set_size(16'(wr), 16'(h));
                    if (h == 0) h = 1;
                end
                3: begin
                    // Broken frame, then a restart by register write.
                    for (int i = 0; i < $urandom_range(1, 20); i++) add_pixel(rand_rgb());
                    set_size(16'(w), 16'(h));
                end
                4: settle();
                default: ;
            endcase
            add_frame(w, h);
        end
        settle();
        $display("Checked %0d filtered pixels over %0d complete frames,", checked, frames_done);
        $display("with %0d requests under random input gaps and output stalls.", n_taken);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
